// ----- hdl/assert_macros.svh -----
// Assertion macros used by the histogram controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ck, rs, ante, cons)
`define ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ----- hdl/jh2d_pkg.sv -----
// Types and constants for the joint histogram.
package jh2d_pkg;

  localparam int MAX_BINS_A  = 256;
  localparam int MAX_BINS_B  = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int POS_A_W   = $clog2(MAX_BINS_A);
  localparam int POS_B_W   = $clog2(MAX_BINS_B);
  localparam int ADDR_W    = POS_A_W + POS_B_W;
  localparam int DEPTH     = MAX_BINS_A * MAX_BINS_B;
  localparam int SCALE_W   = 25;
  localparam int BINS_W    = 9;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = SAMPLE_BITS + SCALE_W;
  localparam int COUNT_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = SCALE_W;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_QUERY_VAL,
    OP_QUERY_POS,
    OP_RESERVED
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_A,
    REG_HIGH_A,
    REG_SCALE_A,
    REG_BINS_A,
    REG_LOW_B,
    REG_HIGH_B,
    REG_SCALE_B,
    REG_BINS_B
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_POS,
    S_READ,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic map;
    logic pos;
    logic read;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } stat_t;

endpackage

// ----- hdl/jh2d_ctrl.sv -----
// Sequencer for the clear pass and the per-word read-modify-write.
`include "assert_macros.svh"

module jh2d_ctrl
  import jh2d_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  output logic   out_valid,
  input  logic   out_stall,
  input  stat_t  stat,
  output cmd_t   cmd
);

  state_t state, state_next;
  logic   go;

  // result slot free, or being taken this cycle
  assign go = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.write) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map    = 1'b1;
        state_next = S_POS;
      end
      S_POS: begin
        cmd.pos    = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (go) begin
          cmd.write  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_accept_map, clk, rst, in_valid && !in_stall, state == S_MAP)
  `ASSERT_IMPL(a_write_slot, clk, rst, cmd.write, !out_valid || !out_stall)
  `ASSERT_NEXT(a_write_valid, clk, rst, cmd.write, out_valid)
  `ASSERT_IMPL(a_one_cmd, clk, rst, 1'b1,
               $onehot0({cmd.clear, cmd.capture, cmd.map, cmd.pos, cmd.read, cmd.write}))
  `ASSERT_NEXT(a_clear_exit, clk, rst, state == S_CLEAR,
               state == S_CLEAR || state == S_IDLE)

endmodule

// ----- hdl/jh2d_dp.sv -----
// Datapath: registers, bin mapping, count store and result register.
module jh2d_dp
  import jh2d_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic [1:0]             op,
  input  logic [SAMPLE_BITS-1:0] value_a,
  input  logic [SAMPLE_BITS-1:0] value_b,
  input  logic [POS_A_W-1:0]     pos_a,
  input  logic [POS_B_W-1:0]     pos_b,
  output logic [COUNT_W-1:0]     count,
  output logic [POS_A_W-1:0]     bin_a,
  output logic [POS_B_W-1:0]     bin_b,
  output logic                   status
);

  logic [SAMPLE_BITS-1:0] low_a, high_a, low_b, high_b;
  logic [SCALE_W-1:0]     scale_a, scale_b;
  logic [BINS_W-1:0]      bins_a, bins_b;

  op_t                    op_r;
  logic [SAMPLE_BITS-1:0] va, vb;
  logic [POS_A_W-1:0]     qa;
  logic [POS_B_W-1:0]     qb;

  logic                   below_a, above_a, below_b, above_b;
  logic [PROD_W-1:0]      prod_a, prod_b;

  logic [POS_A_W-1:0]     pa, pa_next, last_a, map_a;
  logic [POS_B_W-1:0]     pb, pb_next, last_b, map_b;
  logic                   st, st_next;
  logic [ADDR_W-1:0]      clr_addr;

  logic [COUNT_W-1:0]     rd_data, cnt_new;
  logic [COUNT_W-1:0]     mem [0:DEPTH-1];

  logic [SCALE_W-1:0]     frac_a, frac_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_a   <= '0;
      high_a  <= '1;
      scale_a <= SCALE_W'(256);
      bins_a  <= BINS_W'(256);
      low_b   <= '0;
      high_b  <= '1;
      scale_b <= SCALE_W'(256);
      bins_b  <= BINS_W'(256);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LOW_A:   low_a   <= cfg_data[SAMPLE_BITS-1:0];
        REG_HIGH_A:  high_a  <= cfg_data[SAMPLE_BITS-1:0];
        REG_SCALE_A: scale_a <= cfg_data[SCALE_W-1:0];
        REG_BINS_A:  bins_a  <= cfg_data[BINS_W-1:0];
        REG_LOW_B:   low_b   <= cfg_data[SAMPLE_BITS-1:0];
        REG_HIGH_B:  high_b  <= cfg_data[SAMPLE_BITS-1:0];
        REG_SCALE_B: scale_b <= cfg_data[SCALE_W-1:0];
        REG_BINS_B:  bins_b  <= cfg_data[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  // clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end
  assign stat.clear_last = &clr_addr;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= op_t'(op);
      va   <= value_a;
      vb   <= value_b;
      qa   <= pos_a;
      qb   <= pos_b;
    end
  end

  // stage 1: limits and scale multiply
  always_ff @(posedge clk) begin
    if (cmd.map) begin
      below_a <= va < low_a;
      above_a <= high_a <= va;
      below_b <= vb < low_b;
      above_b <= high_b <= vb;
      prod_a  <= PROD_W'(va - low_a) * PROD_W'(scale_a);
      prod_b  <= PROD_W'(vb - low_b) * PROD_W'(scale_b);
    end
  end

  // last bin in use; zero acts as one bin, oversize as the maximum
  always_comb begin
    if (bins_a == '0) begin
      last_a = '0;
    end else if (bins_a > BINS_W'(MAX_BINS_A)) begin
      last_a = POS_A_W'(MAX_BINS_A - 1);
    end else begin
      last_a = POS_A_W'(bins_a - 1'b1);
    end
    if (bins_b == '0) begin
      last_b = '0;
    end else if (bins_b > BINS_W'(MAX_BINS_B)) begin
      last_b = POS_B_W'(MAX_BINS_B - 1);
    end else begin
      last_b = POS_B_W'(bins_b - 1'b1);
    end
  end

  assign frac_a = prod_a[PROD_W-1:FRAC_BITS];
  assign frac_b = prod_b[PROD_W-1:FRAC_BITS];

  always_comb begin
    if (below_a) begin
      map_a = '0;
    end else if (above_a || frac_a > SCALE_W'(last_a)) begin
      map_a = last_a;
    end else begin
      map_a = frac_a[POS_A_W-1:0];
    end
    if (below_b) begin
      map_b = '0;
    end else if (above_b || frac_b > SCALE_W'(last_b)) begin
      map_b = last_b;
    end else begin
      map_b = frac_b[POS_B_W-1:0];
    end
  end

  always_comb begin
    pa_next = '0;
    pb_next = '0;
    st_next = 1'b0;
    unique case (op_r)
      OP_ADD, OP_QUERY_VAL: begin
        pa_next = map_a;
        pb_next = map_b;
      end
      OP_QUERY_POS: begin
        pa_next = qa;
        pb_next = qb;
        st_next = (qa > last_a) || (qb > last_b);
      end
      OP_RESERVED: begin
        st_next = 1'b1;
      end
      default: begin
        st_next = 1'b1;
      end
    endcase
  end

  // stage 2: bin pair and flag
  always_ff @(posedge clk) begin
    if (cmd.pos) begin
      pa <= pa_next;
      pb <= pb_next;
      st <= st_next;
    end
  end

  assign cnt_new = (op_r == OP_ADD && rd_data != '1) ? rd_data + 1'b1 : rd_data;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= '0;
    end else if (cmd.write && op_r == OP_ADD) begin
      mem[{pa, pb}] <= cnt_new;
    end
    if (cmd.read) begin
      rd_data <= mem[{pa, pb}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      count  <= st ? '0 : cnt_new;
      bin_a  <= pa;
      bin_b  <= pb;
      status <= st;
    end
  end

endmodule

// ----- hdl/joint_histogram_2d_top.sv -----
// Joint histogram: an accepted item passes the multiply stage, the bin clamp,
// then a read and a write on the single-port count store; its result word is
// registered at the write, and the next item is taken only after that write.
// A finished word may wait on out_stall while the next item is in flight.
// After rst a clearing pass zeroes all 65536 counts with in_stall high;
// configuration writes are taken throughout.
module joint_histogram_2d_top
  import jh2d_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             op,
  input  logic [SAMPLE_BITS-1:0] value_a,
  input  logic [SAMPLE_BITS-1:0] value_b,
  input  logic [POS_A_W-1:0]     pos_a,
  input  logic [POS_B_W-1:0]     pos_b,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COUNT_W-1:0]     count,
  output logic [POS_A_W-1:0]     bin_a,
  output logic [POS_B_W-1:0]     bin_b,
  output logic                   status,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  jh2d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  jh2d_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .value_a   (value_a),
    .value_b   (value_b),
    .pos_a     (pos_a),
    .pos_b     (pos_b),
    .count     (count),
    .bin_a     (bin_a),
    .bin_b     (bin_b),
    .status    (status)
  );

endmodule

// ----- test/joint_histogram_2d_top_tb.sv -----
// Self-checking testbench for joint_histogram_2d_top: bin mapping, counts and queries.
module joint_histogram_2d_top_tb
  import jh2d_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AX_A = 0;
  localparam int AX_B = 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 205;
  localparam int NUM_PHASES = 8;
  localparam logic [24:0] SCALE_MAX = 25'd16777216;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [POS_A_W-1:0] bin_a;
    logic [POS_B_W-1:0] bin_b;
    logic               status;
  } hist_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             op = OP_ADD;
  logic [SAMPLE_BITS-1:0] value_a = '0;
  logic [SAMPLE_BITS-1:0] value_b = '0;
  logic [POS_A_W-1:0]     pos_a = '0;
  logic [POS_B_W-1:0]     pos_b = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [COUNT_W-1:0]     count;
  logic [POS_A_W-1:0]     bin_a;
  logic [POS_B_W-1:0]     bin_b;
  logic                   status;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_LOW_A;
  logic [CFG_W-1:0]       cfg_data = '0;

  joint_histogram_2d_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .value_a   (value_a),
    .value_b   (value_b),
    .pos_a     (pos_a),
    .pos_b     (pos_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .count     (count),
    .bin_a     (bin_a),
    .bin_b     (bin_b),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor state: register copies per axis and the count store.
  logic [15:0]  lim_lo  [2] = '{16'd0, 16'd0};
  logic [15:0]  lim_hi  [2] = '{16'hFFFF, 16'hFFFF};
  logic [24:0]  scale_r [2] = '{25'd256, 25'd256};
  logic [8:0]   bins_r  [2] = '{9'd256, 9'd256};
  bit   [31:0]  tally   [DEPTH];

  hist_word_t   pending_words [$];
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  int           mismatches = 0;
  int           words_checked = 0;
  int           settings_used = 1;
  int           op_tally [4] = '{0, 0, 0, 0};

  function automatic int clamp_bins(logic [8:0] raw, int maxb);
    if (raw == 0) return 1;
    if (int'(raw) > maxb) return maxb;
    return int'(raw);
  endfunction

  function automatic int bins_in_effect(int ax);
    return clamp_bins(bins_r[ax], (ax == AX_A) ? MAX_BINS_A : MAX_BINS_B);
  endfunction

  function automatic logic [7:0] axis_bin(int ax, logic [15:0] x);
    longint unsigned p;
    int nb;
    nb = bins_in_effect(ax);
    // below-low wins over at-or-above-high when the limits cross
    if (x < lim_lo[ax]) return 8'd0;
    if (lim_hi[ax] <= x) return 8'(nb - 1);
    p = (longint'(x - lim_lo[ax]) * longint'(scale_r[ax])) >> FRAC_BITS;
    if (p > longint'(nb - 1)) p = nb - 1;
    return p[7:0];
  endfunction

  function automatic hist_word_t histogram_apply(op_t o, logic [15:0] va, logic [15:0] vb,
                                                 logic [7:0] qa, logic [7:0] qb);
    hist_word_t w;
    int cell_ix;
    w = '0;
    case (o)
      OP_ADD, OP_QUERY_VAL: begin
        w.bin_a = axis_bin(AX_A, va);
        w.bin_b = axis_bin(AX_B, vb);
        cell_ix = int'(w.bin_a) * MAX_BINS_B + int'(w.bin_b);
        if (o == OP_ADD && tally[cell_ix] != 32'hFFFF_FFFF) tally[cell_ix] += 1;
        w.count = tally[cell_ix];
      end
      OP_QUERY_POS: begin
        w.bin_a = qa;
        w.bin_b = qb;
        if (int'(qa) >= bins_in_effect(AX_A) || int'(qb) >= bins_in_effect(AX_B))
          w.status = 1'b1;
        else
          w.count = tally[int'(qa) * MAX_BINS_B + int'(qb)];
      end
      default: w.status = 1'b1;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 20)
      $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
  endtask

  // Result side: random stall and compare each accepted word with the oldest prediction.
  always @(posedge clk) begin : check_words
    hist_word_t want;
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing pending", count, 32'd0);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (count !== want.count) report_mismatch("count", count, want.count);
        if (bin_a !== want.bin_a) report_mismatch("bin_a", 32'(bin_a), 32'(want.bin_a));
        if (bin_b !== want.bin_b) report_mismatch("bin_b", 32'(bin_b), 32'(want.bin_b));
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d words pending", CYCLE_LIMIT, pending_words.size());
    $display("joint_histogram_2d_top regression: fail");
    $finish;
  end

  // Sends one word; valid stays high afterwards so back-to-back words need no toggle.
  task automatic send_pair(op_t o, logic [15:0] va, logic [15:0] vb,
                           logic [7:0] qa, logic [7:0] qb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    value_a  <= va;
    value_b  <= vb;
    pos_a    <= qa;
    pos_b    <= qb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_words.push_back(histogram_apply(o, va, vb, qa, qb));
    op_tally[o]++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [24:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      REG_LOW_A:   lim_lo[AX_A]  = d[15:0];
      REG_HIGH_A:  lim_hi[AX_A]  = d[15:0];
      REG_SCALE_A: scale_r[AX_A] = d;
      REG_BINS_A:  bins_r[AX_A]  = d[8:0];
      REG_LOW_B:   lim_lo[AX_B]  = d[15:0];
      REG_HIGH_B:  lim_hi[AX_B]  = d[15:0];
      REG_SCALE_B: scale_r[AX_B] = d;
      REG_BINS_B:  bins_r[AX_B]  = d[8:0];
      default: ;
    endcase
  endtask

  task automatic set_binning(logic [15:0] lo_a, logic [15:0] hi_a, logic [24:0] sc_a,
                             logic [8:0] nb_a, logic [15:0] lo_b, logic [15:0] hi_b,
                             logic [24:0] sc_b, logic [8:0] nb_b);
    drain_results();
    write_reg(REG_LOW_A, 25'(lo_a));
    write_reg(REG_HIGH_A, 25'(hi_a));
    write_reg(REG_SCALE_A, sc_a);
    write_reg(REG_BINS_A, 25'(nb_a));
    write_reg(REG_LOW_B, 25'(lo_b));
    write_reg(REG_HIGH_B, 25'(hi_b));
    write_reg(REG_SCALE_B, sc_b);
    write_reg(REG_BINS_B, 25'(nb_b));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic pick_axis(output logic [15:0] lo, output logic [15:0] hi,
                           output logic [24:0] sc, output logic [8:0] nb);
    int unsigned span;
    int unsigned r;
    longint unsigned s;
    lo = 16'($urandom_range(40000));
    span = $urandom_range(65535 - int'(lo), 1);
    hi = 16'(int'(lo) + span);
    if ($urandom_range(9) == 0) begin
      hi = 16'($urandom_range(int'(lo)));
      span = 1;
    end
    r = $urandom_range(99);
    if (r < 60)      nb = 9'($urandom_range(8, 1));
    else if (r < 80) nb = 9'($urandom_range(64, 9));
    else if (r < 90) nb = 9'd256;
    else if (r < 95) nb = 9'd0;
    else             nb = 9'($urandom_range(511, 257));
    s = (longint'(clamp_bins(nb, 256)) * 65536 * $urandom_range(120, 90)) / (100 * span);
    if (s > SCALE_MAX) s = SCALE_MAX;
    sc = ($urandom_range(9) == 0) ? 25'd0 : 25'(s);
  endtask

  function automatic logic [15:0] pick_value(int ax);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 16'($urandom);
    case (r % 5)
      0: return lim_lo[ax] - 16'd1;
      1: return lim_lo[ax];
      2: return lim_hi[ax];
      3: return lim_hi[ax] - 16'd1;
      default: ;
    endcase
    if (lim_hi[ax] > lim_lo[ax])
      return lim_lo[ax] + 16'($urandom_range(int'(lim_hi[ax] - lim_lo[ax])));
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_pos(int ax);
    if ($urandom_range(3) == 0) return 8'($urandom);
    return 8'($urandom_range(bins_in_effect(ax) - 1));
  endfunction

  // Default mapping: bin is value >> 8 on both axes.
  task automatic test_default_map();
    send_pair(OP_ADD, 16'd0, 16'd0, 8'd0, 8'd0);
    send_pair(OP_ADD, 16'd0, 16'd0, 8'hFF, 8'hFF);
    send_pair(OP_ADD, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0);
    send_pair(OP_ADD, 16'hFFFE, 16'd256, 8'd0, 8'd0);
    send_pair(OP_ADD, 16'd255, 16'd511, 8'd0, 8'd0);
    send_pair(OP_QUERY_VAL, 16'd1, 16'd200, 8'd0, 8'd0);
    send_pair(OP_QUERY_POS, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_pair(OP_QUERY_POS, 16'd0, 16'd0, 8'd0, 8'd1);
    send_pair(OP_QUERY_POS, 16'd0, 16'd0, 8'd17, 8'd42);
    send_pair(OP_RESERVED, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
  endtask

  // Crossed limits, zero scale, zero bins on A; max scale and oversized bin count on B.
  task automatic test_degenerate_axes();
    set_binning(16'd100, 16'd50, 25'd0, 9'd0, 16'd1000, 16'd2000, SCALE_MAX, 9'd300);
    send_pair(OP_ADD, 16'd99, 16'd999, 8'd0, 8'd0);
    send_pair(OP_ADD, 16'd100, 16'd1001, 8'd0, 8'd0);
    send_pair(OP_ADD, 16'd40, 16'd2000, 8'd0, 8'd0);
    send_pair(OP_QUERY_VAL, 16'hFFFF, 16'd1000, 8'd0, 8'd0);
    send_pair(OP_QUERY_POS, 16'd0, 16'd0, 8'd0, 8'hFF);
    send_pair(OP_QUERY_POS, 16'd0, 16'd0, 8'd1, 8'd0);
  endtask

  // Few bins in use: positions at and past the edge of the grid.
  task automatic test_narrow_bins();
    set_binning(16'd0, 16'hFFFF, 25'd4, 9'd4, 16'd0, 16'hFFFF, 25'd3, 9'd3);
    send_pair(OP_ADD, 16'hFFFE, 16'hFFFE, 8'd0, 8'd0);
    send_pair(OP_QUERY_POS, 16'd0, 16'd0, 8'd3, 8'd2);
    send_pair(OP_QUERY_POS, 16'd0, 16'd0, 8'd4, 8'd2);
    send_pair(OP_QUERY_POS, 16'd0, 16'd0, 8'd3, 8'd3);
    send_pair(OP_QUERY_POS, 16'd0, 16'd0, 8'hFF, 8'hFF);
  endtask

  // Saturation at all-ones needs 2^32 - 1 adds to one bin and is out of reach here.
  task automatic test_random_phase(int idx, int n_items);
    logic [15:0] lo_a, hi_a, lo_b, hi_b;
    logic [24:0] sc_a, sc_b;
    logic [8:0]  nb_a, nb_b;
    int unsigned r;
    op_t o;
    case (idx)
      0: set_binning(16'd0, 16'hFFFF, 25'd256, 9'd256, 16'd0, 16'hFFFF, 25'd256, 9'd256);
      1: set_binning(16'd0, 16'hFFFF, 25'd256, 9'd1, 16'd0, 16'hFFFF, 25'd256, 9'd1);
      4: set_binning(16'd0, 16'hFFFF, SCALE_MAX, 9'd256, 16'hFFFF, 16'hFFFF, 25'd0, 9'd256);
      default: begin
        pick_axis(lo_a, hi_a, sc_a, nb_a);
        pick_axis(lo_b, hi_b, sc_b, nb_b);
        set_binning(lo_a, hi_a, sc_a, nb_a, lo_b, hi_b, sc_b, nb_b);
      end
    endcase
    case (idx % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 45; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 45; end
      default: begin send_idle_pct = 10; stall_pct = 10; end
    endcase
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) drain_results();
      r = $urandom_range(99);
      if (r < 55)      o = OP_ADD;
      else if (r < 75) o = OP_QUERY_VAL;
      else if (r < 96) o = OP_QUERY_POS;
      else             o = OP_RESERVED;
      send_pair(o, pick_value(AX_A), pick_value(AX_B), pick_pos(AX_A), pick_pos(AX_B));
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin : run
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_map();
    test_degenerate_axes();
    test_narrow_bins();
    for (int p = 0; p < NUM_PHASES; p++) test_random_phase(p, PHASE_ITEMS);
    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d settings: %0d adds, %0d value queries, %0d position queries, %0d reserved",
             settings_used, op_tally[OP_ADD], op_tally[OP_QUERY_VAL], op_tally[OP_QUERY_POS],
             op_tally[OP_RESERVED]);
    $display("%0d result words checked under mixed sender gaps and receiver stalls, %0d mismatches",
             words_checked, mismatches);
    if (mismatches == 0)
      $display("joint_histogram_2d_top regression: pass");
    else
      $display("joint_histogram_2d_top regression: fail");
    $finish;
  end

endmodule
